// File: sv/frm_pkg.sv
// package for the frame rotate, mirror and crop engine: sizes, codes, item types, helpers
package frm_pkg;

   // frame store geometry
   localparam int MaxWidth  = 256;
   localparam int MaxHeight = 256;
   localparam int DimW      = 9;
   localparam int CoordW    = $clog2(MaxWidth > MaxHeight ? MaxWidth : MaxHeight);
   localparam int AddrW     = $clog2(MaxWidth * MaxHeight);
   localparam int CountW    = AddrW + 1;
   localparam int Depth     = MaxWidth * MaxHeight;

   // configuration port
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 9;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_TRANSFORM    = 3'd2,
      CSR_CROP_LEFT    = 3'd3,
      CSR_CROP_TOP     = 3'd4,
      CSR_CROP_COLS    = 3'd5,
      CSR_CROP_ROWS    = 3'd6
   } csr_index_type;

   // transform codes, other codes read out the frame unchanged
   localparam logic [2:0] XF_HMIRROR = 3'd0;
   localparam logic [2:0] XF_VMIRROR = 3'd1;
   localparam logic [2:0] XF_ROT_L   = 3'd2;
   localparam logic [2:0] XF_ROT_R   = 3'd3;
   localparam logic [2:0] XF_CROP    = 3'd4;

   // item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_FETCH = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       last_pixel;
   } rsp_type;

   // zero acts as one, anything above the store size acts as the store size
   function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                 input logic [DimW-1:0] maxv);
      logic [DimW-1:0] r;
      if (v == '0) begin
         r = DimW'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // crop length clipped at the image edge, empty when the origin is outside
   function automatic logic [DimW-1:0] clip_len(input logic [7:0]      origin,
                                                input logic [DimW-1:0] req,
                                                input logic [DimW-1:0] dim);
      logic [DimW-1:0] rem;
      logic [DimW-1:0] r;
      rem = dim - DimW'(origin);
      if (DimW'(origin) >= dim) begin
         r = '0;
      end else if (req < rem) begin
         r = req;
      end else begin
         r = rem;
      end
      return r;
   endfunction

endpackage

// File: sv/frame_rotate_mirror_crop.sv
// top level: frame store with raster load and mirrored, rotated or cropped readout
//
// An item is taken when start is high and busy is low. A load item (mode 0)
// holds busy in the load state after it is taken, so no new item is taken
// while it is written; it writes the next raster position until width*height
// pixels are held and is dropped after that or during readout. A fetch item
// (mode 1) passes a check state, an address state (row times width plus
// column through one multiplier), the registered frame store read, and the
// output state in which rsp_strobe is high with the pixel. The pixel is shown
// for a single cycle and cannot be held off. A fetch that gives no result
// (frame not complete, or readout position outside the output size) frees
// the block from the check state. The frame store needs no clearing after
// reset. Configuration writes take effect at once and belong in
// idle periods.
module frame_rotate_mirror_crop (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  frm_pkg::req_type               req_data,
   output logic                           rsp_strobe,
   output frm_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [frm_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [frm_pkg::CsrDataW-1:0]   csr_wdata
);

   localparam int DimW   = frm_pkg::DimW;
   localparam int CoordW = frm_pkg::CoordW;
   localparam int AddrW  = frm_pkg::AddrW;
   localparam int CountW = frm_pkg::CountW;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_FCHK  = 6'b000100,
      ST_FADDR = 6'b001000,
      ST_FREAD = 6'b010000,
      ST_FOUT  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;

   // configuration registers
   logic [DimW-1:0]     cfg_width_ff, cfg_height_ff;
   logic [2:0]          cfg_xform_ff;
   logic [7:0]          cfg_left_ff, cfg_top_ff;
   logic [DimW-1:0]     cfg_cols_ff, cfg_rows_ff;

   // sequencing state
   logic [CountW-1:0]   count_ff, count_in;
   logic [DimW-1:0]     out_col_ff, out_col_in;
   logic [DimW-1:0]     out_row_ff, out_row_in;
   logic                draining_ff, draining_in;

   // item and datapath registers
   frm_pkg::req_type    req_ff;
   logic [CoordW-1:0]   sx_ff, sx_in;
   logic [CoordW-1:0]   sy_ff, sy_in;
   logic                last_ff, last_in;
   logic [AddrW-1:0]    addr_ff, addr_in;
   logic [23:0]         rd_ff;

   logic [23:0]         mem [frm_pkg::Depth];

   logic [DimW-1:0]     w, h, ow, oh, sx_full, sy_full;
   logic [CountW-1:0]   total;
   logic                frame_full, mem_we;

   // clamped geometry and output size
   always_comb begin
      w     = frm_pkg::clamp_dim(cfg_width_ff, DimW'(frm_pkg::MaxWidth));
      h     = frm_pkg::clamp_dim(cfg_height_ff, DimW'(frm_pkg::MaxHeight));
      total = CountW'(w * h);
      frame_full = (count_ff >= total);
      case (cfg_xform_ff)
         frm_pkg::XF_ROT_L, frm_pkg::XF_ROT_R: begin
            ow = h;
            oh = w;
         end
         frm_pkg::XF_CROP: begin
            ow = frm_pkg::clip_len(cfg_left_ff, cfg_cols_ff, w);
            oh = frm_pkg::clip_len(cfg_top_ff, cfg_rows_ff, h);
         end
         default: begin
            ow = w;
            oh = h;
         end
      endcase
   end

   // source coordinate of the current readout position
   always_comb begin
      case (cfg_xform_ff)
         frm_pkg::XF_HMIRROR: begin
            sx_full = w - DimW'(1) - out_col_ff;
            sy_full = out_row_ff;
         end
         frm_pkg::XF_VMIRROR: begin
            sx_full = out_col_ff;
            sy_full = h - DimW'(1) - out_row_ff;
         end
         frm_pkg::XF_ROT_L: begin
            sx_full = w - DimW'(1) - out_row_ff;
            sy_full = out_col_ff;
         end
         frm_pkg::XF_ROT_R: begin
            sx_full = out_row_ff;
            sy_full = h - DimW'(1) - out_col_ff;
         end
         frm_pkg::XF_CROP: begin
            sx_full = DimW'(cfg_left_ff) + out_col_ff;
            sy_full = DimW'(cfg_top_ff) + out_row_ff;
         end
         default: begin
            sx_full = out_col_ff;
            sy_full = out_row_ff;
         end
      endcase
   end

   assign mem_we = (state_ff == ST_LOAD) && !draining_ff && !frame_full;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      draining_in = draining_ff;
      sx_in       = sx_full[CoordW-1:0];
      sy_in       = sy_full[CoordW-1:0];
      last_in     = (out_col_ff + DimW'(1) == ow) && (out_row_ff + DimW'(1) == oh);
      addr_in     = AddrW'(sy_ff * w + DimW'(sx_ff));
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_data.mode == frm_pkg::MODE_FETCH) ? ST_FCHK : ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (mem_we) begin
               count_in = count_ff + CountW'(1);
            end
            state_in = ST_IDLE;
         end
         ST_FCHK: begin
            if (!draining_ff && !frame_full) begin
               state_in = ST_IDLE;
            end else if (out_col_ff >= ow || out_row_ff >= oh) begin
               // position outside the output size: start over with no item out
               count_in    = '0;
               out_col_in  = '0;
               out_row_in  = '0;
               draining_in = 1'b0;
               state_in    = ST_IDLE;
            end else begin
               draining_in = 1'b1;
               if (last_in) begin
                  count_in    = '0;
                  out_col_in  = '0;
                  out_row_in  = '0;
                  draining_in = 1'b0;
               end else if (out_col_ff + DimW'(1) == ow) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + DimW'(1);
               end else begin
                  out_col_in = out_col_ff + DimW'(1);
               end
               state_in = ST_FADDR;
            end
         end
         ST_FADDR: state_in = ST_FREAD;
         ST_FREAD: state_in = ST_FOUT;
         ST_FOUT:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         draining_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         draining_ff <= draining_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= DimW'(256);
         cfg_height_ff <= DimW'(256);
         cfg_xform_ff  <= frm_pkg::XF_HMIRROR;
         cfg_left_ff   <= '0;
         cfg_top_ff    <= '0;
         cfg_cols_ff   <= DimW'(256);
         cfg_rows_ff   <= DimW'(256);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            frm_pkg::CSR_FRAME_WIDTH:  cfg_width_ff  <= csr_wdata;
            frm_pkg::CSR_FRAME_HEIGHT: cfg_height_ff <= csr_wdata;
            frm_pkg::CSR_TRANSFORM:    cfg_xform_ff  <= csr_wdata[2:0];
            frm_pkg::CSR_CROP_LEFT:    cfg_left_ff   <= csr_wdata[7:0];
            frm_pkg::CSR_CROP_TOP:     cfg_top_ff    <= csr_wdata[7:0];
            frm_pkg::CSR_CROP_COLS:    cfg_cols_ff   <= csr_wdata;
            frm_pkg::CSR_CROP_ROWS:    cfg_rows_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_FCHK) begin
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         last_ff <= last_in;
      end
      if (state_ff == ST_FADDR) begin
         addr_ff <= addr_in;
      end
   end

   // frame store, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AddrW-1:0]] <= {req_ff.red_in, req_ff.green_in, req_ff.blue_in};
      end
      rd_ff <= mem[addr_ff];
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_FOUT);
   assign rsp_data   = '{red_out:    rd_ff[23:16],
                         green_out:  rd_ff[15:8],
                         blue_out:   rd_ff[7:0],
                         last_pixel: last_ff};

`ifndef NO_ASSERTIONS
   // a load item never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == frm_pkg::MODE_LOAD)
      |=> !rsp_strobe ##1 !rsp_strobe ##1 !rsp_strobe)
      else $error("result after a load item");

   // the frame store is never written during readout
   a_no_write_draining: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !draining_ff)
      else $error("frame store written while draining");

   // the last pixel leaves the block ready for a new load
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_pixel)
      |-> (!draining_ff && count_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("last pixel without restart");

   // a result is a single cycle pulse
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");
`endif

endmodule

// File: tb/tb.sv
// self-checking testbench for the frame rotate, mirror and crop engine
module tb;

   localparam int QuietLimit  = 1000;
   localparam int DrainCycles = 20;
   localparam int RandomItems = 1600;

   // transform code outside the defined set, read out unchanged
   localparam logic [2:0] XfPassThrough = 3'd7;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          start      = 1'b0;
   logic                          busy;
   frm_pkg::req_type              req_data   = '0;
   logic                          rsp_strobe;
   frm_pkg::rsp_type              rsp_data;
   logic                          csr_wr_en  = 1'b0;
   logic [frm_pkg::CsrIndexW-1:0] csr_index  = '0;
   logic [frm_pkg::CsrDataW-1:0]  csr_wdata  = '0;

   frame_rotate_mirror_crop dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // shadow copy of the frame store, readout position and registers
   logic [23:0]  frame_copy [frm_pkg::Depth];
   int unsigned  pixels_held;
   int unsigned  col_pos;
   int unsigned  row_pos;
   bit           reading_out;
   logic [8:0]   width_reg  = 9'd256;
   logic [8:0]   height_reg = 9'd256;
   logic [2:0]   xform_reg  = frm_pkg::XF_HMIRROR;
   logic [7:0]   left_reg   = '0;
   logic [7:0]   top_reg    = '0;
   logic [8:0]   cols_reg   = 9'd256;
   logic [8:0]   rows_reg   = 9'd256;

   frm_pkg::rsp_type expected_pixels [$];
   int unsigned  items_used;
   int unsigned  pixels_checked;
   int unsigned  frames_done;
   int unsigned  dry_fetches;
   int unsigned  error_count;
   int unsigned  quiet_cycles;
   int           burst_left;

   always #5 clock = ~clock;

   // size register as the block sees it
   function automatic int unsigned fit_dim(input logic [8:0] v, input int unsigned limit);
      if (v == '0) return 1;
      return (v > limit) ? limit : v;
   endfunction

   function automatic int unsigned frame_pixels();
      return fit_dim(width_reg, frm_pkg::MaxWidth) * fit_dim(height_reg, frm_pkg::MaxHeight);
   endfunction

   // crop length, empty when the origin is past the edge
   function automatic int unsigned crop_len(input int unsigned origin, input int unsigned req,
                                            input int unsigned dim);
      if (origin >= dim) return 0;
      return (req < dim - origin) ? req : dim - origin;
   endfunction

   // width and height of the transformed frame under the current registers
   function automatic void out_shape(output int unsigned ow, output int unsigned oh);
      int unsigned w;
      int unsigned h;
      w = fit_dim(width_reg, frm_pkg::MaxWidth);
      h = fit_dim(height_reg, frm_pkg::MaxHeight);
      case (xform_reg)
         frm_pkg::XF_ROT_L, frm_pkg::XF_ROT_R: begin
            ow = h;
            oh = w;
         end
         frm_pkg::XF_CROP: begin
            ow = crop_len(left_reg, cols_reg, w);
            oh = crop_len(top_reg, rows_reg, h);
         end
         default: begin
            ow = w;
            oh = h;
         end
      endcase
   endfunction

   function automatic void restart_readout();
      pixels_held = 0;
      col_pos     = 0;
      row_pos     = 0;
      reading_out = 1'b0;
   endfunction

   // track one accepted item and queue the pixel it reads out, if any
   function automatic void predict_pixel(input frm_pkg::req_type it);
      int unsigned      w;
      int unsigned      ow;
      int unsigned      oh;
      int unsigned      sx;
      int unsigned      sy;
      frm_pkg::rsp_type px;
      w = fit_dim(width_reg, frm_pkg::MaxWidth);
      items_used++;
      if (it.mode == frm_pkg::MODE_LOAD) begin
         if (!reading_out && pixels_held < frame_pixels()) begin
            frame_copy[pixels_held] = {it.red_in, it.green_in, it.blue_in};
            pixels_held++;
         end
         return;
      end
      if (!reading_out && pixels_held < frame_pixels()) begin
         dry_fetches++;
         return;
      end
      reading_out = 1'b1;
      out_shape(ow, oh);
      // readout position past the output size ends the frame quietly
      if (col_pos >= ow || row_pos >= oh) begin
         dry_fetches++;
         restart_readout();
         return;
      end
      case (xform_reg)
         frm_pkg::XF_HMIRROR: begin
            sx = w - 1 - col_pos;
            sy = row_pos;
         end
         frm_pkg::XF_VMIRROR: begin
            sx = col_pos;
            sy = fit_dim(height_reg, frm_pkg::MaxHeight) - 1 - row_pos;
         end
         frm_pkg::XF_ROT_L: begin
            sx = w - 1 - row_pos;
            sy = col_pos;
         end
         frm_pkg::XF_ROT_R: begin
            sx = row_pos;
            sy = fit_dim(height_reg, frm_pkg::MaxHeight) - 1 - col_pos;
         end
         frm_pkg::XF_CROP: begin
            sx = left_reg + col_pos;
            sy = top_reg + row_pos;
         end
         default: begin
            sx = col_pos;
            sy = row_pos;
         end
      endcase
      {px.red_out, px.green_out, px.blue_out} = frame_copy[sy * w + sx];
      px.last_pixel = (col_pos + 1 == ow) && (row_pos + 1 == oh);
      expected_pixels = {expected_pixels, px};
      if (px.last_pixel) begin
         frames_done++;
         restart_readout();
      end else if (col_pos + 1 == ow) begin
         col_pos = 0;
         row_pos++;
      end else begin
         col_pos++;
      end
   endfunction

   function automatic void report_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endfunction

   // compare each pixel with the oldest one queued
   always @(posedge clock) begin
      frm_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_pixels.size() == 0) begin
            error_count++;
            $display("%0t: pixel expected none got %h", $time, rsp_data);
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            report_field("red_out", want.red_out, rsp_data.red_out);
            report_field("green_out", want.green_out, rsp_data.green_out);
            report_field("blue_out", want.blue_out, rsp_data.blue_out);
            report_field("last_pixel", 8'(want.last_pixel), 8'(rsp_data.last_pixel));
         end
      end
   end

   // watchdog on cycles with no item taken and no pixel out
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] rand_channel();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic frm_pkg::req_type make_item(input logic mode, input logic [7:0] r,
                                                  input logic [7:0] g, input logic [7:0] b);
      frm_pkg::req_type it;
      it.mode     = mode;
      it.red_in   = r;
      it.green_in = g;
      it.blue_in  = b;
      return it;
   endfunction

   function automatic frm_pkg::req_type random_item(input logic mode);
      return make_item(mode, rand_channel(), rand_channel(), rand_channel());
   endfunction

   // hold start until the block takes the item
   task automatic send_item(input frm_pkg::req_type it);
      start    <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_pixel(it);
   endtask

   // sender works in bursts with random gaps between them
   task automatic send_paced(input frm_pkg::req_type it);
      int gap_len;
      if (burst_left <= 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2: gap_len = 0;
            3:       gap_len = $urandom_range(7, 24);
            default: gap_len = $urandom_range(1, 6);
         endcase
         if (gap_len > 0) begin
            start <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      send_item(it);
   endtask

   // wait until every pixel is out and the block has gone quiet
   task automatic settle();
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic put_csr(input frm_pkg::csr_index_type idx,
                          input logic [frm_pkg::CsrDataW-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         frm_pkg::CSR_FRAME_WIDTH:  width_reg  = val;
         frm_pkg::CSR_FRAME_HEIGHT: height_reg = val;
         frm_pkg::CSR_TRANSFORM:    xform_reg  = val[2:0];
         frm_pkg::CSR_CROP_LEFT:    left_reg   = val[7:0];
         frm_pkg::CSR_CROP_TOP:     top_reg    = val[7:0];
         frm_pkg::CSR_CROP_COLS:    cols_reg   = val;
         frm_pkg::CSR_CROP_ROWS:    rows_reg   = val;
         default: ;
      endcase
   endtask

   task automatic program_frame(input logic [8:0] w, input logic [8:0] h, input logic [2:0] xf,
                                input logic [7:0] left, input logic [7:0] top,
                                input logic [8:0] cols, input logic [8:0] rows);
      settle();
      put_csr(frm_pkg::CSR_FRAME_WIDTH, w);
      put_csr(frm_pkg::CSR_FRAME_HEIGHT, h);
      put_csr(frm_pkg::CSR_TRANSFORM, 9'(xf));
      put_csr(frm_pkg::CSR_CROP_LEFT, 9'(left));
      put_csr(frm_pkg::CSR_CROP_TOP, 9'(top));
      put_csr(frm_pkg::CSR_CROP_COLS, cols);
      put_csr(frm_pkg::CSR_CROP_ROWS, rows);
      csr_wr_en <= 1'b0;
   endtask

   // random crop rectangle, mostly near the image, sometimes anywhere
   task automatic program_random_view(input logic [8:0] w, input logic [8:0] h,
                                      input logic [2:0] xf);
      int unsigned span_w;
      int unsigned span_h;
      logic [7:0]  left;
      logic [7:0]  top;
      logic [8:0]  cols;
      logic [8:0]  rows;
      span_w = fit_dim(w, frm_pkg::MaxWidth);
      span_h = fit_dim(h, frm_pkg::MaxHeight);
      left = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, span_w > 255 ? 255 : span_w));
      top  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, span_h > 255 ? 255 : span_h));
      cols = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(0, 511))
                                         : 9'($urandom_range(0, span_w + 1));
      rows = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(0, 511))
                                         : 9'($urandom_range(0, span_h + 1));
      program_frame(w, h, xf, left, top, cols, rows);
   endtask

   // load until the store holds a full frame, stray fetches mixed in when noisy
   task automatic fill_frame(input bit noisy);
      while (pixels_held < frame_pixels()) begin
         if (noisy && $urandom_range(0, 9) == 0) begin
            send_paced(random_item(frm_pkg::MODE_FETCH));
         end else begin
            send_paced(random_item(frm_pkg::MODE_LOAD));
         end
      end
      // loads into a full store are dropped
      if (noisy && $urandom_range(0, 1) == 0) begin
         repeat ($urandom_range(1, 3)) send_paced(random_item(frm_pkg::MODE_LOAD));
      end
   endtask

   // fetch until the block returns to loading, optionally changing the view midway
   task automatic drain_frame(input bit noisy, input int reprogram_at);
      int fetches;
      fetches = 0;
      do begin
         if (noisy && $urandom_range(0, 9) == 0) begin
            send_paced(random_item(frm_pkg::MODE_LOAD));
         end else begin
            send_paced(random_item(frm_pkg::MODE_FETCH));
            fetches++;
         end
         if (fetches == reprogram_at && reading_out) begin
            program_random_view(width_reg, height_reg, 3'($urandom_range(0, 7)));
            reprogram_at = -1;
         end
      end while (reading_out || fetches == 0);
      // fetches with nothing pending
      if (noisy && $urandom_range(0, 1) == 0) begin
         repeat ($urandom_range(1, 2)) send_paced(random_item(frm_pkg::MODE_FETCH));
      end
   endtask

   // fetch on a frame that is not yet complete, at the reset sizes
   task automatic test_fetch_before_full();
      send_paced(make_item(frm_pkg::MODE_LOAD, 8'hff, 8'h00, 8'hff));
      send_paced(make_item(frm_pkg::MODE_FETCH, 8'h00, 8'h00, 8'h00));
   endtask

   // right rotation of a 3x1 frame, then a fetch after the end
   task automatic test_rotate_and_full_load();
      program_frame(9'd3, 9'd1, frm_pkg::XF_ROT_R, 8'd0, 8'd0, 9'd256, 9'd256);
      send_paced(make_item(frm_pkg::MODE_LOAD, 8'h00, 8'hff, 8'h00));
      send_paced(make_item(frm_pkg::MODE_LOAD, 8'hff, 8'hff, 8'hff));
      send_paced(make_item(frm_pkg::MODE_LOAD, 8'h12, 8'h34, 8'h56));
      repeat (4) send_paced(make_item(frm_pkg::MODE_FETCH, 8'hff, 8'hff, 8'hff));
   endtask

   // crop origin past the right edge
   task automatic test_empty_crop();
      program_frame(9'd2, 9'd1, frm_pkg::XF_CROP, 8'd2, 8'd0, 9'd256, 9'd256);
      send_paced(make_item(frm_pkg::MODE_LOAD, 8'h01, 8'h02, 8'h03));
      send_paced(make_item(frm_pkg::MODE_LOAD, 8'h80, 8'h40, 8'h20));
      send_paced(make_item(frm_pkg::MODE_FETCH, 8'h00, 8'h00, 8'h00));
   endtask

   // view shrinks under the readout position, load during readout is dropped
   task automatic test_reprogram_mid_readout();
      program_frame(9'd2, 9'd2, frm_pkg::XF_HMIRROR, 8'd0, 8'd0, 9'd256, 9'd256);
      repeat (4) send_paced(random_item(frm_pkg::MODE_LOAD));
      send_paced(random_item(frm_pkg::MODE_FETCH));
      send_paced(random_item(frm_pkg::MODE_LOAD));
      send_paced(random_item(frm_pkg::MODE_FETCH));
      program_frame(9'd2, 9'd2, frm_pkg::XF_CROP, 8'd0, 8'd0, 9'd2, 9'd1);
      send_paced(random_item(frm_pkg::MODE_FETCH));
   endtask

   // zero width acts as one, unknown transform code passes the frame through
   task automatic test_size_clamp();
      program_frame(9'd0, 9'd1, XfPassThrough, 8'd0, 8'd0, 9'd256, 9'd256);
      send_paced(make_item(frm_pkg::MODE_LOAD, 8'h00, 8'h00, 8'h00));
      send_paced(make_item(frm_pkg::MODE_FETCH, 8'h00, 8'h00, 8'h00));
   endtask

   // random frames: mostly small, a few at the size limits, every transform code
   task automatic test_random_frames();
      int unsigned first_item;
      int unsigned frame_idx;
      int          pick;
      logic [8:0]  w;
      logic [8:0]  h;
      logic [2:0]  xf;
      bit          noisy;
      first_item = items_used;
      frame_idx  = 0;
      while (items_used - first_item < RandomItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            w = 9'($urandom_range(1, 8));
            h = 9'($urandom_range(1, 8));
         end else if (pick < 92) begin
            w = 9'($urandom_range(1, 24));
            h = 9'($urandom_range(1, 24));
         end else if (pick < 96) begin
            w = 9'($urandom_range(256, 511));
            h = 9'($urandom_range(0, 1));
         end else begin
            w = 9'($urandom_range(0, 1));
            h = 9'($urandom_range(256, 511));
         end
         xf = (frame_idx < 8) ? 3'(frame_idx) : 3'($urandom_range(0, 7));
         program_random_view(w, h, xf);
         noisy = ($urandom_range(0, 4) == 0);
         fill_frame(noisy);
         drain_frame(noisy, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : -1);
         frame_idx++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_fetch_before_full();
      test_rotate_and_full_load();
      test_empty_crop();
      test_reprogram_mid_readout();
      test_size_clamp();
      test_random_frames();
      settle();
      $display("covered %0d loads and fetches, %0d pixels compared, %0d frames read to the end",
               items_used, pixels_checked, frames_done);
      $display("%0d fetches gave no pixel (frame incomplete, empty view or view cut short)",
               dry_fetches);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
